FILE: hdl/cblt_pkg.sv
// Package: shared types, codes and sizes for the cache block LRU tag store.
package cblt_pkg;

    localparam int DEF_NUM_ENTRIES = 64;
    localparam int FILE_W  = 32;
    localparam int BLOCK_W = 40;
    localparam int STAMP_W = 48;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 6;
    localparam int FREE_W  = 7;

    localparam logic [ACT_W-1:0] ACT_LOOKUP_FILL = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP_ONLY = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FILL_OK     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FILL_FAIL   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FLUSH       = 3'd4;

    localparam logic [STAT_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STAT_W-1:0] ST_WAIT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_ALLOC = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISS  = 3'd4;
    localparam logic [STAT_W-1:0] ST_DONE  = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [FILE_W-1:0]  file_id;
        logic [BLOCK_W-1:0] block_number;
        logic [IDX_W-1:0]   fill_block;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  entry_index;
        logic [FREE_W-1:0] free_slots;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture input transaction
        logic scan;    // sweep one entry
        logic commit;  // apply update, build result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

FILE: hdl/cblt_datapath.sv
// Datapath and its generic RAM: entry tags and stamps in RAM, pipelined sweep, updates.
module cblt_datapath #(
    parameter int NUM_ENTRIES = cblt_pkg::DEF_NUM_ENTRIES,
    parameter int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cblt_pkg::in_item_t  in_item,
    input  cblt_pkg::cmd_t      cmd,
    output cblt_pkg::sts_t      sts,
    output cblt_pkg::out_item_t result
);
    import cblt_pkg::*;

    localparam int CW    = $clog2(NUM_ENTRIES + 1);
    localparam int TAG_W = FILE_W + BLOCK_W;

    // valid bit also masks stale RAM words: an invalid entry reads as stamp 0
    logic [NUM_ENTRIES-1:0] valid_reg, pending_reg;
    logic [STAMP_W-1:0] counter_reg, counter_inc;
    logic [CW-1:0]      pcount_reg;

    in_item_t           req_reg;
    logic [IW-1:0]      addr_reg;
    logic               issued_all_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic               rd_vld_reg;
    logic               hit_found_reg, vic_found_reg;
    logic [IW-1:0]      hit_idx_reg, vic_idx_reg;
    logic [STAMP_W-1:0] vic_stamp_reg;
    out_item_t          result_reg;

    logic [TAG_W-1:0]   tag_rdata, tag_wdata;
    logic [STAMP_W-1:0] stamp_rdata, stamp_eff;
    logic               tag_we, stamp_we;
    logic [IW-1:0]      wr_idx;
    logic               match, vic_better, fb_ok;
    logic [IW-1:0]      fb_idx;

    cblt_ram #(.WIDTH(TAG_W), .DEPTH(NUM_ENTRIES), .AW(IW)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (wr_idx),
        .wdata (tag_wdata),
        .raddr (addr_reg),
        .rdata (tag_rdata)
    );

    cblt_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_ENTRIES), .AW(IW)) u_stamp_ram (
        .aclk  (aclk),
        .we    (stamp_we),
        .waddr (wr_idx),
        .wdata (counter_inc),
        .raddr (addr_reg),
        .rdata (stamp_rdata)
    );

    assign stamp_eff = valid_reg[rd_idx_reg] ? stamp_rdata : '0;
    assign match = valid_reg[rd_idx_reg]
                   && (tag_rdata == {req_reg.file_id, req_reg.block_number});
    assign vic_better = !pending_reg[rd_idx_reg]
                        && (!vic_found_reg || stamp_eff < vic_stamp_reg);
    assign sts.scan_last = rd_vld_reg && (32'(rd_idx_reg) == NUM_ENTRIES - 1);
    assign counter_inc = (counter_reg == {STAMP_W{1'b1}}) ? counter_reg
                                                           : counter_reg + 1'b1;
    assign fb_idx = IW'(req_reg.fill_block);
    assign fb_ok = ({26'd0, req_reg.fill_block} < NUM_ENTRIES) && pending_reg[fb_idx];
    assign tag_wdata = {req_reg.file_id, req_reg.block_number};
    assign result = result_reg;

    // RAM writes happen only in the commit cycle
    always_comb begin
        tag_we   = 1'b0;
        stamp_we = 1'b0;
        wr_idx   = '0;
        if (cmd.commit) begin
            case (req_reg.action)
                ACT_LOOKUP_FILL, ACT_LOOKUP_ONLY: begin
                    if (hit_found_reg) begin
                        if (!pending_reg[hit_idx_reg]) begin
                            stamp_we = 1'b1;
                            wr_idx   = hit_idx_reg;
                        end
                    end else if (req_reg.action == ACT_LOOKUP_FILL && vic_found_reg) begin
                        tag_we   = 1'b1;
                        stamp_we = 1'b1;
                        wr_idx   = vic_idx_reg;
                    end
                end
                ACT_FILL_OK: begin
                    if (fb_ok) begin
                        stamp_we = 1'b1;
                        wr_idx   = fb_idx;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            pending_reg    <= '0;
            counter_reg    <= '0;
            pcount_reg     <= '0;
            addr_reg       <= '0;
            issued_all_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            vic_found_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                req_reg        <= in_item;
                addr_reg       <= '0;
                issued_all_reg <= 1'b0;
                rd_vld_reg     <= 1'b0;
                hit_found_reg  <= 1'b0;
                vic_found_reg  <= 1'b0;
            end
            if (cmd.scan) begin
                // issue stage: one RAM read per cycle
                rd_vld_reg <= !issued_all_reg;
                rd_idx_reg <= addr_reg;
                if (32'(addr_reg) == NUM_ENTRIES - 1) issued_all_reg <= 1'b1;
                else                                  addr_reg <= addr_reg + 1'b1;
                // compare stage: entry read in the previous cycle
                if (rd_vld_reg) begin
                    if (match && !hit_found_reg) begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= rd_idx_reg;
                    end
                    if (vic_better) begin
                        vic_found_reg <= 1'b1;
                        vic_idx_reg   <= rd_idx_reg;
                        vic_stamp_reg <= stamp_eff;
                    end
                end
            end
            if (cmd.commit) begin
                result_reg.status      <= ST_DONE;
                result_reg.entry_index <= '0;
                result_reg.free_slots  <= FREE_W'(NUM_ENTRIES) - FREE_W'(pcount_reg);
                case (req_reg.action)
                    ACT_LOOKUP_FILL, ACT_LOOKUP_ONLY: begin
                        if (hit_found_reg) begin
                            result_reg.entry_index <= IDX_W'(hit_idx_reg);
                            if (pending_reg[hit_idx_reg]) begin
                                result_reg.status <= ST_WAIT;
                            end else begin
                                result_reg.status <= ST_HIT;
                                counter_reg       <= counter_inc;
                            end
                        end else if (req_reg.action == ACT_LOOKUP_ONLY) begin
                            result_reg.status <= ST_MISS;
                        end else if (vic_found_reg) begin
                            valid_reg[vic_idx_reg]   <= 1'b1;
                            pending_reg[vic_idx_reg] <= 1'b1;
                            counter_reg              <= counter_inc;
                            pcount_reg               <= pcount_reg + 1'b1;
                            result_reg.status        <= ST_ALLOC;
                            result_reg.entry_index   <= IDX_W'(vic_idx_reg);
                            result_reg.free_slots    <= FREE_W'(NUM_ENTRIES)
                                                        - FREE_W'(pcount_reg) - 1'b1;
                        end else begin
                            result_reg.status <= ST_FULL;
                        end
                    end
                    ACT_FILL_OK, ACT_FILL_FAIL: begin
                        if (fb_ok) begin
                            pending_reg[fb_idx] <= 1'b0;
                            pcount_reg          <= pcount_reg - 1'b1;
                            result_reg.free_slots <= FREE_W'(NUM_ENTRIES)
                                                     - FREE_W'(pcount_reg) + 1'b1;
                            if (req_reg.action == ACT_FILL_OK) begin
                                counter_reg <= counter_inc;
                            end else begin
                                valid_reg[fb_idx] <= 1'b0;
                            end
                        end
                    end
                    ACT_FLUSH: begin
                        valid_reg   <= '0;
                        pending_reg <= '0;
                        pcount_reg  <= '0;
                        result_reg.free_slots <= FREE_W'(NUM_ENTRIES);
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// Generic single-port-write RAM with registered read.
module cblt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

endmodule

FILE: hdl/cblt_ctrl.sv
// Controller: sequences load, sweep, commit and result handoff.
module cblt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  cblt_pkg::sts_t sts,
    output cblt_pkg::cmd_t cmd
);
    import cblt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = (state_reg == S_OUT);
    assign cmd.load   = s_valid && s_ready;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.commit = (state_reg == S_COMMIT);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_SCAN;
            S_SCAN:   if (sts.scan_last) state_next = S_COMMIT;
            S_COMMIT: state_next = S_OUT;
            S_OUT:    if (m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule

FILE: hdl/cache_block_lru_tag_store.sv
// Top level: fully associative LRU tag store with fill-pending tracking.
// Usage:
//   s_ channel carries one request transaction (action, file_id,
//   block_number, fill_block); m_ channel returns exactly one result
//   transaction (status, entry_index, free_slots) per request.
//   Both are valid/ready; a transaction moves when valid and ready are high.
// Operation:
//   One request at a time. Tags and stamps sit in RAM with registered
//   read, so the sweep reads one entry per cycle and compares it once
//   the registered read data and index arrive, looking for the lowest
//   matching entry and the oldest non-pending victim (ties to lowest
//   index); then the commit step updates state.
//   Next request is taken the cycle after the result is accepted.
// Reset:
//   aresetn (sync, active low) clears all valid and pending bits, the use
//   counter and pending count; nothing is pending on either channel afterward.
// Stall:
//   If m_ready is low the result holds on m_ with m_valid high and
//   s_ready stays low until it is taken.
module cache_block_lru_tag_store #(
    parameter int NUM_ENTRIES = cblt_pkg::DEF_NUM_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cblt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cblt_pkg::out_item_t m_data
);
    import cblt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cblt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cblt_datapath #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_item (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (m_data)
    );

endmodule

FILE: verif/testbench.sv
// Testbench for the cache block LRU tag store: directed table and fill sequence, then random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cblt_pkg::*;

    localparam int NENT = DEF_NUM_ENTRIES;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam int EXP_DEPTH = 16;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    cache_block_lru_tag_store #(.NUM_ENTRIES(NENT)) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #5 aclk = ~aclk;

    // Mirror of the tag array.
    logic               tag_valid   [NENT];
    logic [FILE_W-1:0]  tag_file    [NENT];
    logic [BLOCK_W-1:0] tag_block   [NENT];
    logic [STAMP_W-1:0] tag_stamp   [NENT];
    logic               tag_pending [NENT];
    logic [STAMP_W-1:0] use_count;
    int                 pending_fills;

    // Expected results, in order of acceptance.
    out_item_t exp_fifo [EXP_DEPTH];
    int        sent_count = 0;
    int        recv_count = 0;
    int        error_count = 0;
    longint    cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    // Directed table: expected result typed only for obvious rows.
    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    function automatic void mirror_reset();
        for (int i = 0; i < NENT; i++) begin
            tag_valid[i] = 0; tag_file[i] = '0; tag_block[i] = '0;
            tag_stamp[i] = '0; tag_pending[i] = 0;
        end
        use_count = '0;
        pending_fills = 0;
    endfunction

    function automatic void stamp_entry(int i);
        if (use_count != STAMP_MAX) use_count++;
        tag_stamp[i] = use_count;
    endfunction

    // Predicts the result of one request and advances the mirror.
    function automatic out_item_t predict_lookup(in_item_t r);
        out_item_t o;
        int hit_idx;
        int victim;
        o.status = ST_DONE;
        o.entry_index = '0;
        hit_idx = -1;
        victim = -1;
        if (r.action == ACT_LOOKUP_FILL || r.action == ACT_LOOKUP_ONLY) begin
            for (int i = NENT - 1; i >= 0; i--)
                if (tag_valid[i] && tag_file[i] == r.file_id &&
                    tag_block[i] == r.block_number) hit_idx = i;
            if (hit_idx >= 0) begin
                o.entry_index = hit_idx[IDX_W-1:0];
                if (tag_pending[hit_idx]) o.status = ST_WAIT;
                else begin
                    stamp_entry(hit_idx);
                    o.status = ST_HIT;
                end
            end else if (r.action == ACT_LOOKUP_ONLY) begin
                o.status = ST_MISS;
            end else begin
                for (int i = 0; i < NENT; i++)
                    if (!tag_pending[i] && (victim < 0 || tag_stamp[i] < tag_stamp[victim]))
                        victim = i;
                if (victim >= 0) begin
                    tag_valid[victim] = 1;
                    tag_file[victim] = r.file_id;
                    tag_block[victim] = r.block_number;
                    stamp_entry(victim);
                    tag_pending[victim] = 1;
                    pending_fills++;
                    o.entry_index = victim[IDX_W-1:0];
                    o.status = ST_ALLOC;
                end else o.status = ST_FULL;
            end
        end else if (r.action == ACT_FILL_OK || r.action == ACT_FILL_FAIL) begin
            if (int'(r.fill_block) < NENT && tag_pending[r.fill_block]) begin
                if (r.action == ACT_FILL_OK) begin
                    stamp_entry(r.fill_block);
                    tag_pending[r.fill_block] = 0;
                end else begin
                    tag_valid[r.fill_block] = 0; tag_file[r.fill_block] = '0;
                    tag_block[r.fill_block] = '0; tag_stamp[r.fill_block] = '0;
                    tag_pending[r.fill_block] = 0;
                end
                pending_fills--;
            end
        end else if (r.action == ACT_FLUSH) begin
            for (int i = 0; i < NENT; i++) begin
                tag_valid[i] = 0; tag_file[i] = '0; tag_block[i] = '0;
                tag_stamp[i] = '0; tag_pending[i] = 0;
            end
            pending_fills = 0;
        end
        o.free_slots = FREE_W'(NENT - pending_fills);
        return o;
    endfunction

    // Sends one request transaction; the expectation is stored at acceptance.
    // Starts and ends at a falling edge; valid stays high into the next request.
    task automatic send_request(in_item_t r, bit typed = 0, out_item_t want = '0);
        out_item_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = predict_lookup(r);
        // typed rows double-check the predictor itself
        if (typed && p != want) begin
            $error("table row mismatch: expected %h predicted %h", want, p);
            error_count++;
        end
        exp_fifo[sent_count % EXP_DEPTH] = p;
        sent_count++;
        @(negedge aclk);
    endtask

    // Receiver: random stall, compare each result transaction with the oldest expectation.
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        out_item_t e;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (recv_count == sent_count) begin
                $error("unexpected result transaction %h", m_data);
                error_count++;
            end else begin
                e = exp_fifo[recv_count % EXP_DEPTH];
                recv_count++;
                if (m_data.status != e.status) begin
                    $error("status: expected %0d actual %0d", e.status, m_data.status);
                    error_count++;
                end
                if (m_data.entry_index != e.entry_index) begin
                    $error("entry_index: expected %0d actual %0d",
                           e.entry_index, m_data.entry_index);
                    error_count++;
                end
                if (m_data.free_slots != e.free_slots) begin
                    $error("free_slots: expected %0d actual %0d",
                           e.free_slots, m_data.free_slots);
                    error_count++;
                end
            end
        end
    end

    function automatic in_item_t mk(logic [ACT_W-1:0] a, logic [FILE_W-1:0] f,
                                    logic [BLOCK_W-1:0] b, logic [IDX_W-1:0] fb);
        in_item_t r;
        r.action = a; r.file_id = f; r.block_number = b; r.fill_block = fb;
        return r;
    endfunction

    function automatic out_item_t res(logic [STAT_W-1:0] s, logic [IDX_W-1:0] i,
                                      logic [FREE_W-1:0] fr);
        out_item_t o;
        o.status = s; o.entry_index = i; o.free_slots = fr;
        return o;
    endfunction

    // Random request: small tag pool so hits, waits and full cases happen.
    function automatic in_item_t rand_request(int pool);
        in_item_t r;
        int k;
        int pick;
        k = $urandom_range(pool - 1);
        pick = $urandom_range(99);
        if (pick < 45) r.action = ACT_LOOKUP_FILL;
        else if (pick < 60) r.action = ACT_LOOKUP_ONLY;
        else if (pick < 80) r.action = ACT_FILL_OK;
        else if (pick < 95) r.action = ACT_FILL_FAIL;
        else if (pick < 97) r.action = ACT_FLUSH;
        else r.action = ACT_W'($urandom_range(7, 5));
        if ($urandom_range(9) == 0) begin
            r.file_id = $urandom();
            r.block_number = {8'($urandom()), $urandom()};
        end else begin
            r.file_id = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'(k)};
            r.block_number = {$urandom_range(1) ? 8'hFF : 8'h00, 32'(k * 3)};
        end
        r.fill_block = 6'($urandom());
        return r;
    endfunction

    initial begin
        dir_row_t dir_table [16];
        int phase_pct [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{20, 20}};

        mirror_reset();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: extremes, every action, the special cases.
        // Row 8 on: block 0 pending must not hide idle entries.
        dir_table = '{
            '{mk(ACT_LOOKUP_ONLY, '0, '0, '0), 1, res(ST_MISS, 6'd0, 7'd64)},
            '{mk(ACT_FILL_OK, '1, '1, 6'd63), 1, res(ST_DONE, 6'd0, 7'd64)},
            '{mk(ACT_FILL_FAIL, '0, '0, 6'd0), 1, res(ST_DONE, 6'd0, 7'd64)},
            '{mk(ACT_LOOKUP_FILL, '0, '0, '0), 1, res(ST_ALLOC, 6'd0, 7'd63)},
            '{mk(ACT_LOOKUP_FILL, '0, '0, '0), 1, res(ST_WAIT, 6'd0, 7'd63)},
            '{mk(ACT_LOOKUP_FILL, '1, '1, '1), 1, res(ST_ALLOC, 6'd1, 7'd62)},
            '{mk(ACT_LOOKUP_ONLY, '1, '1, '0), 1, res(ST_WAIT, 6'd1, 7'd62)},
            '{mk(ACT_FILL_OK, '0, '0, 6'd1), 0, '0},
            '{mk(ACT_LOOKUP_ONLY, '1, '1, '0), 0, '0},
            '{mk(ACT_LOOKUP_FILL, 32'h1234_5678, 40'hAB_CDEF_0123, '0), 0, '0},
            '{mk(ACT_FILL_FAIL, '0, '0, 6'd0), 0, '0},
            '{mk(ACT_LOOKUP_ONLY, '0, '0, '0), 0, '0},
            '{mk(3'd5, '1, '1, '1), 0, '0},
            '{mk(3'd6, '0, '0, '0), 0, '0},
            '{mk(3'd7, '1, '0, '1), 0, '0},
            '{mk(ACT_FLUSH, '0, '0, '0), 1, res(ST_DONE, 6'd0, 7'd64)}
        };
        foreach (dir_table[i])
            send_request(dir_table[i].req, dir_table[i].typed, dir_table[i].want);

        // Fill every entry to reach the no-free-block case, then release them.
        for (int i = 0; i < NENT; i++)
            send_request(mk(ACT_LOOKUP_FILL, 32'(i) + 32'h100, 40'(i), '0));
        send_request(mk(ACT_LOOKUP_FILL, '1, '1, '0), 1, res(ST_FULL, 6'd0, 7'd0));
        for (int i = 0; i < NENT; i++)
            send_request(mk(ACT_FILL_OK, '0, '0, 6'(i)));

        // Random part, four idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            for (int n = 0; n < 320; n++)
                send_request(rand_request(ph[0] ? 80 : 24));
        end
        s_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        while (recv_count != sent_count) @(posedge aclk);
        repeat (3 * NENT) @(posedge aclk);
        if (error_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: sim.f
hdl/cblt_pkg.sv
hdl/cblt_datapath.sv
hdl/cblt_ctrl.sv
hdl/cache_block_lru_tag_store.sv
verif/testbench.sv
